>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/gfv_pkg.sv
package gfv_pkg;

    // Store geometry and counter width.
    localparam int DIM        = 512;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (DIM > 1) ? $clog2(DIM) : 1;

    // Shared unit datapath widths.
    localparam int WIDE_W = 96;
    localparam int DIV_W  = 64;
    localparam int ACC_W  = 48;

    localparam logic [63:0] ACC_MAX64 = 64'h0000_7FFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        AU_MUL  = 2'd0,
        AU_DIV  = 2'd1,
        AU_SQRT = 2'd2
    } au_op_t;

    typedef struct packed {
        au_op_t              op;
        logic [WIDE_W-1:0]   x;
        logic [DIV_W-1:0]    y;
    } au_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } au_stat_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_READ,
        S_CHECK,
        S_SQRT_V,
        S_DIV_M,
        S_DIV_P2,
        S_MUL_VS,
        S_MUL_AA,
        S_DIV_P1,
        S_ACC,
        S_DIV_G1,
        S_SQRT_G1,
        S_DIV_G2,
        S_SQRT_G2,
        S_MUL_M,
        S_MUL_D,
        S_OUT
    } state_t;

    // Saturate a widened accumulator sum to the signed 48-bit range.
    function automatic logic [ACC_W-1:0] acc_sat(input logic signed [50:0] s);
        logic signed [50:0] hi;
        logic signed [50:0] lo;
        hi = 51'sh0_7FFF_FFFF_FFFF;
        lo = -hi - 51'sd1;
        if (s > hi)
            acc_sat = hi[ACC_W-1:0];
        else if (s < lo)
            acc_sat = lo[ACC_W-1:0];
        else
            acc_sat = s[ACC_W-1:0];
    endfunction

    // Magnitude of a signed 48-bit accumulator.
    function automatic logic [ACC_W-1:0] acc_mag(input logic [ACC_W-1:0] a);
        acc_mag = a[ACC_W-1] ? (ACC_W'(0) - a) : a;
    endfunction

    // Apply sign and clip to 32 bits; bit 32 is the clip flag.
    function automatic logic [32:0] scale_clip(input logic neg, input logic [55:0] p);
        if (neg) begin
            if (p > 56'h0000_0080_0000_00)
                scale_clip = {1'b1, 32'h8000_0000};
            else
                scale_clip = {1'b0, 32'(56'd0 - p)};
        end
        else begin
            if (p > 56'h0000_007F_FFFF_FF)
                scale_clip = {1'b1, 32'h7FFF_FFFF};
            else
                scale_clip = {1'b0, p[31:0]};
        end
    endfunction

endpackage

>>> design/gaussian_fisher_vector_encoder_core.sv
// Single-Gaussian Fisher vector encoder, signed Q16.16.
// Command channel: an item is taken at a clock edge where start is high and
// busy is low; op selects load model entry, add word element, clear document
// or read result. Only a read gives a result: out_valid is high for exactly
// one cycle with out_index, mean_gradient, deviation_gradient and saturated,
// and the receiver cannot stall it.
// All arithmetic runs through one shared unit that does shift-add multiply,
// restoring divide and square root, one bit per cycle (64, 96 and 32 steps,
// with a launch before and a hand-back after each operation).
// An add element runs one square root, three divides and two multiplies, and
// skips them when the entry has zero variance or the index is out of range.
// A read runs two divides, two square roots and two multiplies before the
// result beat, or none for a zero answer. Busy is high for the whole of each item.
// After reset, and for each clear document, the block sweeps the accumulator
// memories, one entry per cycle, over all DIM (512) entries, with busy high.
// The word count is cleared at reset and by clear document; the model memories
// are left as they are.
`include "assert_macros.svh"

module gaussian_fisher_vector_encoder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [8:0]         dim_index,
    input  logic signed [31:0] elem_value,
    input  logic signed [31:0] model_mean,
    input  logic [30:0]        model_variance,
    input  logic               word_end,
    output logic               out_valid,
    output logic [8:0]         out_index,
    output logic signed [31:0] mean_gradient,
    output logic signed [31:0] deviation_gradient,
    output logic               saturated
);

    localparam int IW = gfv_pkg::IDX_W;
    localparam int CB = gfv_pkg::COUNT_BITS;

    gfv_pkg::state_t         state_reg, state_next;
    logic                    launched_reg, launched_next;
    logic [IW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [CB-1:0]           count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;

    gfv_pkg::op_t            op_reg, op_next;
    logic [8:0]              idx_reg, idx_next;
    logic [31:0]             elem_reg, elem_next;
    logic [31:0]             mean_in_reg, mean_in_next;
    logic [30:0]             var_in_reg, var_in_next;
    logic                    wend_reg, wend_next;

    logic [32:0]             a_reg, a_next;
    logic                    dneg_reg, dneg_next;
    logic [23:0]             s_reg, s_next;
    logic [48:0]             mm_reg, mm_next;
    logic [24:0]             p2_reg, p2_next;
    logic [54:0]             vs_reg, vs_next;
    logic [64:0]             aa_reg, aa_next;
    logic [46:0]             p1_reg, p1_next;
    logic [62:0]             q_reg, q_next;
    logic [31:0]             g1_reg, g1_next;
    logic [31:0]             g2_reg, g2_next;
    logic [79:0]             pm_reg, pm_next;
    logic [79:0]             pd_reg, pd_next;

    logic [8:0]              oidx_reg, oidx_next;
    logic [31:0]             omg_reg, omg_next;
    logic [31:0]             odg_reg, odg_next;
    logic                    osat_reg, osat_next;

    logic [IW-1:0]           addr;
    logic                    idx_ok;
    logic                    mem_we;
    logic                    acc_we;
    logic [IW-1:0]           acc_waddr;
    logic [gfv_pkg::ACC_W-1:0] macc_wdata, dacc_wdata;
    logic [31:0]             mean_rd;
    logic [30:0]             var_rd;
    logic [gfv_pkg::ACC_W-1:0] macc_rd, dacc_rd;

    logic                    u_start;
    gfv_pkg::au_cmd_t        u_cmd;
    gfv_pkg::au_stat_t       u_stat;
    logic [gfv_pkg::WIDE_W-1:0] u_result;

    logic [32:0]             d_full;
    logic [50:0]             mt, dt;
    logic [32:0]             sm, sd;
    logic [63:0]             p1_raw;

    assign addr   = IW'(idx_reg);
    assign idx_ok = 32'(idx_reg) < 32'(gfv_pkg::DIM);

    // Model and accumulator memories.
    gfv_ram #(.WIDTH(32), .DEPTH(gfv_pkg::DIM)) u_mean_ram (
        .clk(clk), .we(mem_we), .waddr(addr), .wdata(mean_in_reg),
        .raddr(addr), .rdata(mean_rd)
    );

    gfv_ram #(.WIDTH(31), .DEPTH(gfv_pkg::DIM)) u_var_ram (
        .clk(clk), .we(mem_we), .waddr(addr), .wdata(var_in_reg),
        .raddr(addr), .rdata(var_rd)
    );

    gfv_ram #(.WIDTH(gfv_pkg::ACC_W), .DEPTH(gfv_pkg::DIM)) u_macc_ram (
        .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(macc_wdata),
        .raddr(addr), .rdata(macc_rd)
    );

    gfv_ram #(.WIDTH(gfv_pkg::ACC_W), .DEPTH(gfv_pkg::DIM)) u_dacc_ram (
        .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(dacc_wdata),
        .raddr(addr), .rdata(dacc_rd)
    );

    // Shared multiply, divide and square-root unit.
    gfv_arith u_arith (
        .clk(clk), .rst_n(rst_n), .start(u_start), .cmd(u_cmd),
        .stat(u_stat), .result(u_result)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gfv_pkg::S_CLEAR;
            launched_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            clr_cnt_reg   <= clr_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        elem_reg    <= elem_next;
        mean_in_reg <= mean_in_next;
        var_in_reg  <= var_in_next;
        wend_reg    <= wend_next;
        a_reg       <= a_next;
        dneg_reg    <= dneg_next;
        s_reg       <= s_next;
        mm_reg      <= mm_next;
        p2_reg      <= p2_next;
        vs_reg      <= vs_next;
        aa_reg      <= aa_next;
        p1_reg      <= p1_next;
        q_reg       <= q_next;
        g1_reg      <= g1_next;
        g2_reg      <= g2_next;
        pm_reg      <= pm_next;
        pd_reg      <= pd_next;
        oidx_reg    <= oidx_next;
        omg_reg     <= omg_next;
        odg_reg     <= odg_next;
        osat_reg    <= osat_next;
    end

    // Sequencer: next state, unit commands and memory writes.
    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        clr_cnt_next   = clr_cnt_reg;
        count_next     = count_reg;
        out_valid_next = 1'b0;
        op_next        = op_reg;
        idx_next       = idx_reg;
        elem_next      = elem_reg;
        mean_in_next   = mean_in_reg;
        var_in_next    = var_in_reg;
        wend_next      = wend_reg;
        a_next         = a_reg;
        dneg_next      = dneg_reg;
        s_next         = s_reg;
        mm_next        = mm_reg;
        p2_next        = p2_reg;
        vs_next        = vs_reg;
        aa_next        = aa_reg;
        p1_next        = p1_reg;
        q_next         = q_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        pm_next        = pm_reg;
        pd_next        = pd_reg;
        oidx_next      = oidx_reg;
        omg_next       = omg_reg;
        odg_next       = odg_reg;
        osat_next      = osat_reg;

        mem_we     = 1'b0;
        acc_we     = 1'b0;
        acc_waddr  = addr;
        macc_wdata = '0;
        dacc_wdata = '0;
        u_cmd      = '{op: gfv_pkg::AU_MUL, x: '0, y: '0};

        d_full = {elem_reg[31], elem_reg} - {mean_rd[31], mean_rd};
        mt     = dneg_reg ? (51'd0 - 51'(mm_reg)) : 51'(mm_reg);
        dt     = 51'(p1_reg) - 51'(p2_reg);
        sm     = gfv_pkg::scale_clip(macc_rd[gfv_pkg::ACC_W-1], pm_reg[79:24]);
        sd     = gfv_pkg::scale_clip(dacc_rd[gfv_pkg::ACC_W-1], pd_reg[79:24]);
        p1_raw = u_result[63:0];

        // Operand selection for each arithmetic step.
        case (state_reg)
            gfv_pkg::S_SQRT_V:
                u_cmd = '{op: gfv_pkg::AU_SQRT, x: 96'({var_rd, 16'd0}), y: '0};
            gfv_pkg::S_DIV_M:
                u_cmd = '{op: gfv_pkg::AU_DIV, x: 96'({a_reg, 16'd0}), y: 64'(var_rd)};
            gfv_pkg::S_DIV_P2:
                u_cmd = '{op: gfv_pkg::AU_DIV, x: 96'(64'h1_0000_0000), y: 64'(s_reg)};
            gfv_pkg::S_MUL_VS:
                u_cmd = '{op: gfv_pkg::AU_MUL, x: 96'(var_rd), y: 64'(s_reg)};
            gfv_pkg::S_MUL_AA:
                u_cmd = '{op: gfv_pkg::AU_MUL, x: 96'(a_reg), y: 64'(a_reg)};
            gfv_pkg::S_DIV_P1:
                u_cmd = '{op: gfv_pkg::AU_DIV, x: 96'({aa_reg, 16'd0}), y: 64'(vs_reg)};
            gfv_pkg::S_DIV_G1:
                u_cmd = '{op: gfv_pkg::AU_DIV, x: 96'({var_rd, 32'd0}),
                          y: 64'(count_reg)};
            gfv_pkg::S_SQRT_G1:
                u_cmd = '{op: gfv_pkg::AU_SQRT, x: 96'(q_reg), y: '0};
            gfv_pkg::S_DIV_G2:
                u_cmd = '{op: gfv_pkg::AU_DIV, x: 96'({var_rd, 32'd0}),
                          y: 64'({count_reg, 1'b0})};
            gfv_pkg::S_SQRT_G2:
                u_cmd = '{op: gfv_pkg::AU_SQRT, x: 96'(q_reg), y: '0};
            gfv_pkg::S_MUL_M:
                u_cmd = '{op: gfv_pkg::AU_MUL, x: 96'(gfv_pkg::acc_mag(macc_rd)),
                          y: 64'(g1_reg)};
            gfv_pkg::S_MUL_D:
                u_cmd = '{op: gfv_pkg::AU_MUL, x: 96'(gfv_pkg::acc_mag(dacc_rd)),
                          y: 64'(g2_reg)};
            default:
                u_cmd = '{op: gfv_pkg::AU_MUL, x: '0, y: '0};
        endcase

        // Launch the unit once per arithmetic state.
        u_start = 1'b0;
        case (state_reg)
            gfv_pkg::S_SQRT_V, gfv_pkg::S_DIV_M, gfv_pkg::S_DIV_P2,
            gfv_pkg::S_MUL_VS, gfv_pkg::S_MUL_AA, gfv_pkg::S_DIV_P1,
            gfv_pkg::S_DIV_G1, gfv_pkg::S_SQRT_G1, gfv_pkg::S_DIV_G2,
            gfv_pkg::S_SQRT_G2, gfv_pkg::S_MUL_M, gfv_pkg::S_MUL_D:
            begin
                if (!launched_reg)
                begin
                    u_start       = 1'b1;
                    launched_next = 1'b1;
                end
                else if (u_stat.done)
                begin
                    launched_next = 1'b0;
                end
            end
            default:
                u_start = 1'b0;
        endcase

        case (state_reg)
            gfv_pkg::S_CLEAR:
            begin
                acc_we       = 1'b1;
                acc_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                count_next   = '0;
                if (clr_cnt_reg == IW'(gfv_pkg::DIM - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = gfv_pkg::S_IDLE;
                end
            end
            gfv_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next      = gfv_pkg::op_t'(op);
                    idx_next     = dim_index;
                    elem_next    = elem_value;
                    mean_in_next = model_mean;
                    var_in_next  = model_variance;
                    wend_next    = word_end;
                    case (gfv_pkg::op_t'(op))
                        gfv_pkg::OP_LOAD:  state_next = gfv_pkg::S_LOAD;
                        gfv_pkg::OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = gfv_pkg::S_CLEAR;
                        end
                        default:           state_next = gfv_pkg::S_READ;
                    endcase
                end
            end
            gfv_pkg::S_LOAD:
            begin
                mem_we     = idx_ok;
                state_next = gfv_pkg::S_IDLE;
            end
            gfv_pkg::S_READ:
            begin
                state_next = gfv_pkg::S_CHECK;
            end
            gfv_pkg::S_CHECK:
            begin
                if (op_reg == gfv_pkg::OP_ADD)
                begin
                    if (wend_reg && (count_reg != {CB{1'b1}}))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    dneg_next = d_full[32];
                    a_next    = d_full[32] ? (33'd0 - d_full) : d_full;
                    if (idx_ok && (var_rd != '0))
                        state_next = gfv_pkg::S_SQRT_V;
                    else
                        state_next = gfv_pkg::S_IDLE;
                end
                else
                begin
                    if (idx_ok && (var_rd != '0) && (count_reg != '0))
                    begin
                        state_next = gfv_pkg::S_DIV_G1;
                    end
                    else
                    begin
                        oidx_next      = idx_reg;
                        omg_next       = '0;
                        odg_next       = '0;
                        osat_next      = 1'b0;
                        out_valid_next = 1'b1;
                        state_next     = gfv_pkg::S_IDLE;
                    end
                end
            end
            gfv_pkg::S_SQRT_V:
            begin
                if (launched_reg && u_stat.done)
                begin
                    s_next     = u_result[23:0];
                    state_next = gfv_pkg::S_DIV_M;
                end
            end
            gfv_pkg::S_DIV_M:
            begin
                if (launched_reg && u_stat.done)
                begin
                    mm_next    = u_result[48:0];
                    state_next = gfv_pkg::S_DIV_P2;
                end
            end
            gfv_pkg::S_DIV_P2:
            begin
                if (launched_reg && u_stat.done)
                begin
                    p2_next    = u_result[24:0];
                    state_next = gfv_pkg::S_MUL_VS;
                end
            end
            gfv_pkg::S_MUL_VS:
            begin
                if (launched_reg && u_stat.done)
                begin
                    vs_next    = u_result[54:0];
                    state_next = gfv_pkg::S_MUL_AA;
                end
            end
            gfv_pkg::S_MUL_AA:
            begin
                if (launched_reg && u_stat.done)
                begin
                    aa_next    = u_result[64:0];
                    state_next = gfv_pkg::S_DIV_P1;
                end
            end
            gfv_pkg::S_DIV_P1:
            begin
                // The squared term is capped at the accumulator maximum.
                if (launched_reg && u_stat.done)
                begin
                    if (u_stat.ovf || (p1_raw > gfv_pkg::ACC_MAX64))
                        p1_next = gfv_pkg::ACC_MAX64[46:0];
                    else
                        p1_next = p1_raw[46:0];
                    state_next = gfv_pkg::S_ACC;
                end
            end
            gfv_pkg::S_ACC:
            begin
                acc_we     = 1'b1;
                macc_wdata = gfv_pkg::acc_sat(
                    {{3{macc_rd[gfv_pkg::ACC_W-1]}}, macc_rd} + mt);
                dacc_wdata = gfv_pkg::acc_sat(
                    {{3{dacc_rd[gfv_pkg::ACC_W-1]}}, dacc_rd} + dt);
                state_next = gfv_pkg::S_IDLE;
            end
            gfv_pkg::S_DIV_G1:
            begin
                if (launched_reg && u_stat.done)
                begin
                    q_next     = u_result[62:0];
                    state_next = gfv_pkg::S_SQRT_G1;
                end
            end
            gfv_pkg::S_SQRT_G1:
            begin
                if (launched_reg && u_stat.done)
                begin
                    g1_next    = u_result[31:0];
                    state_next = gfv_pkg::S_DIV_G2;
                end
            end
            gfv_pkg::S_DIV_G2:
            begin
                if (launched_reg && u_stat.done)
                begin
                    q_next     = u_result[62:0];
                    state_next = gfv_pkg::S_SQRT_G2;
                end
            end
            gfv_pkg::S_SQRT_G2:
            begin
                if (launched_reg && u_stat.done)
                begin
                    g2_next    = u_result[31:0];
                    state_next = gfv_pkg::S_MUL_M;
                end
            end
            gfv_pkg::S_MUL_M:
            begin
                if (launched_reg && u_stat.done)
                begin
                    pm_next    = u_result[79:0];
                    state_next = gfv_pkg::S_MUL_D;
                end
            end
            gfv_pkg::S_MUL_D:
            begin
                if (launched_reg && u_stat.done)
                begin
                    pd_next    = u_result[79:0];
                    state_next = gfv_pkg::S_OUT;
                end
            end
            gfv_pkg::S_OUT:
            begin
                oidx_next      = idx_reg;
                omg_next       = sm[31:0];
                odg_next       = sd[31:0];
                osat_next      = sm[32] | sd[32];
                out_valid_next = 1'b1;
                state_next     = gfv_pkg::S_IDLE;
            end
            default:
                state_next = gfv_pkg::S_IDLE;
        endcase
    end

    assign busy               = (state_reg != gfv_pkg::S_IDLE);
    assign out_valid          = out_valid_reg;
    assign out_index          = oidx_reg;
    assign mean_gradient      = omg_reg;
    assign deviation_gradient = odg_reg;
    assign saturated          = osat_reg;

    `ASSERT_IMPLIES(a_valid_src, clk, rst_n, out_valid_reg,
        $past(state_reg == gfv_pkg::S_OUT) || $past(state_reg == gfv_pkg::S_CHECK))
    `ASSERT_IMPLIES(a_unit_free, clk, rst_n, u_start, !u_stat.busy)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

endmodule

>>> design/gfv_ram.sv
module gfv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/gfv_arith.sv
`include "assert_macros.svh"

module gfv_arith (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  gfv_pkg::au_cmd_t            cmd,
    output gfv_pkg::au_stat_t           stat,
    output logic [gfv_pkg::WIDE_W-1:0]  result
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        ovf_reg, ovf_next;
    gfv_pkg::au_op_t             mode_reg, mode_next;
    logic [6:0]                  cnt_reg, cnt_next;
    logic [gfv_pkg::WIDE_W-1:0]  x_reg, x_next;
    logic [gfv_pkg::DIV_W-1:0]   y_reg, y_next;
    logic [gfv_pkg::WIDE_W-1:0]  acc_reg, acc_next;
    logic [63:0]                 rem_reg, rem_next;

    logic [gfv_pkg::WIDE_W-1:0]  mul_sum;
    logic [64:0]                 div_sh;
    logic                        div_ge;
    logic [64:0]                 div_diff;
    logic [34:0]                 sq_rem;
    logic [34:0]                 sq_trial;
    logic                        sq_ge;
    logic [34:0]                 sq_diff;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        ovf_reg  <= ovf_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
    end

    // One shift-add, restoring-divide or square-root step per cycle.
    always_comb
    begin
        mul_sum  = acc_reg + (y_reg[0] ? x_reg : '0);
        div_sh   = {rem_reg, x_reg[gfv_pkg::WIDE_W-1]};
        div_ge   = div_sh >= {1'b0, y_reg};
        div_diff = div_sh - {1'b0, y_reg};
        sq_rem   = {rem_reg[32:0], x_reg[63:62]};
        sq_trial = {1'b0, acc_reg[31:0], 2'b01};
        sq_ge    = sq_rem >= sq_trial;
        sq_diff  = sq_rem - sq_trial;

        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;

        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            mode_next = cmd.op;
            x_next    = cmd.x;
            y_next    = cmd.y;
            acc_next  = '0;
            rem_next  = '0;
            ovf_next  = 1'b0;
            case (cmd.op)
                gfv_pkg::AU_MUL:  cnt_next = 7'd64;
                gfv_pkg::AU_DIV:  cnt_next = 7'd96;
                gfv_pkg::AU_SQRT: cnt_next = 7'd32;
                default:          cnt_next = 7'd1;
            endcase
        end
        else if (busy_reg)
        begin
            case (mode_reg)
                gfv_pkg::AU_MUL:
                begin
                    acc_next = mul_sum;
                    x_next   = {x_reg[gfv_pkg::WIDE_W-2:0], 1'b0};
                    y_next   = {1'b0, y_reg[gfv_pkg::DIV_W-1:1]};
                end
                gfv_pkg::AU_DIV:
                begin
                    x_next   = {x_reg[gfv_pkg::WIDE_W-2:0], 1'b0};
                    rem_next = div_ge ? div_diff[63:0] : div_sh[63:0];
                    ovf_next = ovf_reg | acc_reg[63];
                    acc_next = {32'd0, acc_reg[62:0], div_ge};
                end
                gfv_pkg::AU_SQRT:
                begin
                    x_next   = {x_reg[gfv_pkg::WIDE_W-3:0], 2'b00};
                    rem_next = sq_ge ? 64'(sq_diff) : 64'(sq_rem);
                    acc_next = {64'd0, acc_reg[30:0], sq_ge};
                end
                default:
                begin
                    acc_next = '0;
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign stat   = '{busy: busy_reg, done: done_reg, ovf: ovf_reg};
    assign result = acc_reg;

    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `ASSERT_NEXT(a_launch_busy, clk, rst_n, start && !busy_reg, busy_reg)
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)

endmodule

>>> tb/tb_gaussian_fisher_vector_encoder_core.sv
`timescale 1ns / 1ps

module tb_gaussian_fisher_vector_encoder_core;

    localparam int          CYCLE_LIMIT = 4000000;
    localparam int          DRAIN_WAIT  = 1000;
    localparam logic [47:0] GRAD_MAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] GRAD_MIN    = 48'h8000_0000_0000;

    // One result beat as the block should present it.
    typedef struct {
        logic [8:0]  idx;
        logic [31:0] mg;
        logic [31:0] dg;
        logic        sat;
    } grad_beat_t;

    // One row of the directed table; zero_ans rows carry a hand-typed zero answer.
    typedef struct {
        gfv_pkg::op_t op;
        int          idx;
        logic [31:0] elem;
        logic [31:0] mean;
        logic [30:0] vr;
        bit          wend;
        bit          zero_ans;
    } cmd_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    gfv_pkg::op_t       op = gfv_pkg::OP_LOAD;
    logic [8:0]         dim_index = '0;
    logic signed [31:0] elem_value = '0;
    logic signed [31:0] model_mean = '0;
    logic [30:0]        model_variance = '0;
    logic               word_end = 1'b0;
    logic               out_valid;
    logic [8:0]         out_index;
    logic signed [31:0] mean_gradient;
    logic signed [31:0] deviation_gradient;
    logic               saturated;

    // Predictor state: model tables, gradient accumulators and the word count.
    logic signed [31:0] mean_tbl [gfv_pkg::DIM];
    logic [30:0]        var_tbl [gfv_pkg::DIM];
    bit                 loaded [gfv_pkg::DIM];
    logic signed [47:0] mgrad_acc [gfv_pkg::DIM];
    logic signed [47:0] dgrad_acc [gfv_pkg::DIM];
    longint unsigned    words;
    int                 loaded_dims [$];

    grad_beat_t         pending_grads [$];
    int                 mismatches = 0;
    int                 cycles = 0;

    gaussian_fisher_vector_encoder_core uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .op                 (op),
        .dim_index          (dim_index),
        .elem_value         (elem_value),
        .model_mean         (model_mean),
        .model_variance     (model_variance),
        .word_end           (word_end),
        .out_valid          (out_valid),
        .out_index          (out_index),
        .mean_gradient      (mean_gradient),
        .deviation_gradient (deviation_gradient),
        .saturated          (saturated)
    );

    always #2 clk = ~clk;

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Saturating add into a 48-bit gradient accumulator.
    function automatic logic signed [47:0] grad_add(input logic signed [47:0] a,
                                                    input logic signed [63:0] t);
        logic signed [63:0] s;
        s = 64'(a) + t;
        if (s > signed'(64'(GRAD_MAX)))
            return GRAD_MAX;
        if (s < 64'(signed'(GRAD_MIN)))
            return GRAD_MIN;
        return s[47:0];
    endfunction

    // Scale an accumulator by a Q8.24 gain and clip to 32 bits.
    function automatic logic [31:0] grad_scale(input logic signed [47:0] acc,
                                               input longint unsigned g,
                                               inout logic sat);
        logic [127:0] mag;
        logic [127:0] p;
        mag = acc[47] ? 128'(-64'(acc)) : 128'(acc);
        p = (mag * 128'(g)) >> 24;
        if (acc[47])
        begin
            if (p > 128'h8000_0000)
            begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(0 - p[31:0]);
        end
        if (p > 128'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return p[31:0];
    endfunction

    // Advance the predictor by one accepted beat and queue any result.
    task automatic encode_beat(input cmd_row_t c);
        longint unsigned v;
        longint signed   d;
        longint unsigned a;
        longint unsigned s;
        longint unsigned mm;
        longint unsigned p2;
        logic [127:0]    p1;
        longint unsigned g1;
        longint unsigned g2;
        grad_beat_t      r;
        case (c.op)
            gfv_pkg::OP_LOAD:
            begin
                mean_tbl[c.idx] = c.mean;
                var_tbl[c.idx] = c.vr;
                if (!loaded[c.idx])
                    loaded_dims = {loaded_dims, c.idx};
                loaded[c.idx] = 1'b1;
            end
            gfv_pkg::OP_ADD:
            begin
                v = var_tbl[c.idx];
                if (v != 0)
                begin
                    d = longint'(signed'(c.elem)) - longint'(mean_tbl[c.idx]);
                    a = d < 0 ? -d : d;
                    s = int_sqrt(v << 16);
                    mm = (a << 16) / v;
                    p1 = (128'(a << 16) * 128'(a)) / 128'(v * s);
                    if (p1 > 128'(GRAD_MAX))
                        p1 = 128'(GRAD_MAX);
                    p2 = (64'd1 << 32) / s;
                    mgrad_acc[c.idx] = grad_add(mgrad_acc[c.idx], d < 0 ? -mm : mm);
                    dgrad_acc[c.idx] = grad_add(dgrad_acc[c.idx], p1[63:0] - p2);
                end
                if (c.wend && words < 65535)
                    words++;
            end
            gfv_pkg::OP_CLEAR:
            begin
                foreach (mgrad_acc[i])
                begin
                    mgrad_acc[i] = '0;
                    dgrad_acc[i] = '0;
                end
                words = 0;
            end
            default:
            begin
                r = '{idx: c.idx, mg: '0, dg: '0, sat: 1'b0};
                v = var_tbl[c.idx];
                if (!c.zero_ans && v != 0 && words != 0)
                begin
                    g1 = int_sqrt((v << 32) / words);
                    g2 = int_sqrt((v << 32) / (2 * words));
                    r.mg = grad_scale(mgrad_acc[c.idx], g1, r.sat);
                    r.dg = grad_scale(dgrad_acc[c.idx], g2, r.sat);
                end
                pending_grads = {pending_grads, r};
            end
        endcase
    endtask

    // Present one beat, hold it until the block takes it, then idle with start low when gap is nonzero.
    task automatic issue(input cmd_row_t c, input int gap);
        start <= 1'b1;
        op <= c.op;
        dim_index <= c.idx[8:0];
        elem_value <= c.elem;
        model_mean <= c.mean;
        model_variance <= c.vr;
        word_end <= c.wend;
        do
            @(posedge clk);
        while (busy);
        encode_beat(c);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [30:0] pick_variance();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r < 4)
            return 31'($urandom_range(1, 32'hFFFF));
        if (r < 7)
            return 31'($urandom_range(32'h8000, 32'h40000));
        return 31'($urandom);
    endfunction

    // Result check against the oldest expectation.
    always @(posedge clk)
    begin
        grad_beat_t e;
        if (out_valid)
        begin
            if (pending_grads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: index %0d", out_index);
            end
            else
            begin
                e = pending_grads.pop_front();
                if (out_index !== e.idx || mean_gradient !== e.mg
                    || deviation_gradient !== e.dg || saturated !== e.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp idx %0d mg %h dg %h sat %b, got %0d %h %h %b",
                                 e.idx, e.mg, e.dg, e.sat, out_index, mean_gradient,
                                 deviation_gradient, saturated);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        cmd_row_t directed [22] = '{
            '{gfv_pkg::OP_LOAD,  0,   32'h0, 32'h0,         31'h0001_0000, 1'b0, 1'b0},
            '{gfv_pkg::OP_LOAD,  511, 32'h0, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0, 1'b0},
            '{gfv_pkg::OP_LOAD,  5,   32'h0, 32'h1234_5678, 31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_LOAD,  1,   32'h0, 32'h7FFF_FFFF, 31'h1,         1'b0, 1'b0},
            '{gfv_pkg::OP_READ,  0,   32'h0, 32'h0,         31'h0,         1'b0, 1'b1},
            '{gfv_pkg::OP_ADD,   0,   32'h7FFF_FFFF, 32'h0, 31'h0,         1'b1, 1'b0},
            '{gfv_pkg::OP_ADD,   0,   32'h8000_0000, 32'h0, 31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_ADD,   511, 32'h7FFF_FFFF, 32'h0, 31'h0,         1'b1, 1'b0},
            '{gfv_pkg::OP_ADD,   511, 32'h8000_0000, 32'h0, 31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_ADD,   5,   32'h0001_0000, 32'h0, 31'h0,         1'b1, 1'b0},
            '{gfv_pkg::OP_READ,  5,   32'h0, 32'h0,         31'h0,         1'b0, 1'b1},
            '{gfv_pkg::OP_READ,  0,   32'h0, 32'h0,         31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_READ,  511, 32'h0, 32'h0,         31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_ADD,   1,   32'h8000_0000, 32'h0, 31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_ADD,   1,   32'h8000_0000, 32'h0, 31'h0,         1'b1, 1'b0},
            '{gfv_pkg::OP_READ,  1,   32'h0, 32'h0,         31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_ADD,   0,   32'h0, 32'h0,         31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_READ,  0,   32'h0, 32'h0,         31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_CLEAR, 0,   32'h0, 32'h0,         31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_READ,  511, 32'h0, 32'h0,         31'h0,         1'b0, 1'b1},
            '{gfv_pkg::OP_ADD,   0,   32'h0002_0000, 32'h0, 31'h0,         1'b0, 1'b0},
            '{gfv_pkg::OP_READ,  0,   32'h0, 32'h0,         31'h0,         1'b0, 1'b1}
        };
        cmd_row_t c;
        int       r;
        int       waited;

        foreach (mgrad_acc[i])
        begin
            mgrad_acc[i] = '0;
            dgrad_acc[i] = '0;
            loaded[i] = 1'b0;
            var_tbl[i] = '0;
            mean_tbl[i] = '0;
        end
        words = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; every entry is loaded before it is first used.
        foreach (directed[i])
            issue(directed[i], pick_gap());

        // Reads with a zero word count, then a fresh document.
        c = '{gfv_pkg::OP_READ, 511, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0};
        issue(c, 2);
        c = '{gfv_pkg::OP_READ, 1, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0};
        issue(c, 2);
        c = '{gfv_pkg::OP_CLEAR, 0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0};
        issue(c, 1);

        // Random traffic: mostly element adds and reads on loaded dimensions.
        repeat (525)
        begin
            r = $urandom_range(99);
            c = '{gfv_pkg::OP_ADD, 0, 32'($urandom), 32'($urandom), 31'h0,
                  1'($urandom), 1'b0};
            if (r < 15)
            begin
                c.op = gfv_pkg::OP_LOAD;
                c.idx = $urandom_range(gfv_pkg::DIM - 1);
                c.vr = pick_variance();
                if ($urandom_range(1))
                    c.mean = 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
            end
            else if (r < 72)
            begin
                c.idx = loaded_dims[$urandom_range(loaded_dims.size() - 1)];
                if ($urandom_range(3) != 0)
                    c.elem = mean_tbl[c.idx] + 32'($urandom_range(32'h0004_0000))
                             - 32'h0002_0000;
            end
            else if (r < 97)
            begin
                c.op = gfv_pkg::OP_READ;
                c.idx = loaded_dims[$urandom_range(loaded_dims.size() - 1)];
            end
            else
                c.op = gfv_pkg::OP_CLEAR;
            issue(c, pick_gap());
        end
        start <= 1'b0;

        waited = 0;
        while (pending_grads.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending_grads.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/gfv_pkg.sv
design/gfv_ram.sv
design/gfv_arith.sv
design/gaussian_fisher_vector_encoder_core.sv
tb/tb_gaussian_fisher_vector_encoder_core.sv
